@@ design/dro_pkg.sv @@
// Package for the odometry block: types, register codes, microprogram and sine table maths.
package dro_pkg;

   localparam int SINE_TABLE_DEPTH_DEF   = 1024;
   localparam int POSITION_FRACTION_BITS = 16;
   localparam int TABLE_FRACTION_BITS    = 15;
   localparam int POS_WIDTH              = 48;
   localparam int HEADING_WIDTH          = 32;
   localparam int DELTA_WIDTH            = 16;
   localparam int TRIG_WIDTH             = 16;
   localparam int CSR_DATA_WIDTH         = 48;
   localparam int STEP_BITS              = 3;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef enum logic [1:0] {
      CSR_TURN_PER_PULSE = 2'd0,
      CSR_START_X        = 2'd1,
      CSR_START_Y        = 2'd2,
      CSR_START_HEADING  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   typedef enum logic [1:0] {
      JMP_NEXT     = 2'd0,
      JMP_WAIT_REQ = 2'd1,
      JMP_WAIT_RSP = 2'd2
   } jump_type;

   typedef enum logic [1:0] {
      MUL_PHASE = 2'd0,
      MUL_COS   = 2'd1,
      MUL_SIN   = 2'd2
   } mul_src_type;

   typedef struct packed {
      jump_type    jump;
      mul_src_type mul_src;
      logic        ld_heading;
      logic        ld_phase;
      logic        rom_rd;
      logic        ld_prod;
      logic        acc_x;
      logic        acc_y;
   } ucode_type;

   localparam ucode_type UC_IDLE = '{jump: JMP_WAIT_REQ, mul_src: MUL_PHASE, ld_heading: 1'b1,
                                     ld_phase: 1'b0, rom_rd: 1'b0, ld_prod: 1'b0,
                                     acc_x: 1'b0, acc_y: 1'b0};

   // microprogram: heading, phase, table read, cos product, x + sin product, y + emit
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type uc;
      uc = UC_IDLE;
      uc.ld_heading = 1'b0;
      unique case (step)
         3'd0: uc = UC_IDLE;
         3'd1: begin
            uc.jump     = JMP_NEXT;
            uc.mul_src  = MUL_PHASE;
            uc.ld_phase = 1'b1;
         end
         3'd2: begin
            uc.jump   = JMP_NEXT;
            uc.rom_rd = 1'b1;
         end
         3'd3: begin
            uc.jump    = JMP_NEXT;
            uc.mul_src = MUL_COS;
            uc.ld_prod = 1'b1;
         end
         3'd4: begin
            uc.jump    = JMP_NEXT;
            uc.mul_src = MUL_SIN;
            uc.ld_prod = 1'b1;
            uc.acc_x   = 1'b1;
         end
         3'd5: begin
            uc.jump  = JMP_WAIT_RSP;
            uc.acc_y = 1'b1;
         end
         default: uc = UC_IDLE;
      endcase
      return uc;
   endfunction

   function automatic logic [TRIG_WIDTH-1:0] to_q15(input longint v);
      logic [63:0] c;
      logic [63:0] t;
      c = (v < 0) ? 64'd0 : ((v > longint'(ONE_Q30)) ? ONE_Q30 : 64'(v));
      t = c * 64'd32767 + (64'd1 << 29);
      return t[45:30];
   endfunction

   // first quadrant sine and cosine, Q2.30 series, packed as {sin, cos} in Q1.15
   function automatic logic [2*TRIG_WIDTH-1:0] quarter_entry(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      s;
      longint      c;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      term = term * x2 / 64'd6;   s = s - longint'(term);
      term = term * x2 / 64'd20;  s = s + longint'(term);
      term = term * x2 / 64'd42;  s = s - longint'(term);
      term = term * x2 / 64'd72;  s = s + longint'(term);
      term = term * x2 / 64'd110; s = s - longint'(term);
      term = term * x2 / 64'd156; s = s + longint'(term);
      term = ONE_Q30;
      c    = longint'(ONE_Q30);
      term = term * x2 / 64'd2;   c = c - longint'(term);
      term = term * x2 / 64'd12;  c = c + longint'(term);
      term = term * x2 / 64'd30;  c = c - longint'(term);
      term = term * x2 / 64'd56;  c = c + longint'(term);
      term = term * x2 / 64'd90;  c = c - longint'(term);
      term = term * x2 / 64'd132; c = c + longint'(term);
      term = term * x2 / 64'd182; c = c - longint'(term);
      return {to_q15(s), to_q15(c)};
   endfunction

endpackage

@@ design/dro_if.sv @@
// Item channel interfaces for odometry requests and results.
interface dro_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [dro_pkg::DELTA_WIDTH-1:0]      delta_distance;
   logic signed [dro_pkg::DELTA_WIDTH-1:0]      delta_orientation;

   modport source (output valid, output delta_distance, output delta_orientation, input ready);
   modport sink   (input valid, input delta_distance, input delta_orientation, output ready);
endinterface

interface dro_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [dro_pkg::POS_WIDTH-1:0]        pos_x;
   logic signed [dro_pkg::POS_WIDTH-1:0]        pos_y;
   logic signed [dro_pkg::HEADING_WIDTH-1:0]    heading;
   logic                                        saturated;

   modport source (output valid, output pos_x, output pos_y, output heading, output saturated,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input heading, input saturated,
                   output ready);
endinterface

@@ design/dead_reckoning_odometry.sv @@
// Dead-reckoning odometry top level: microcoded sequencer over one shared multiplier.
// An accepted item runs the phase, table read (registered sine/cosine ROM), cos and sin
// product steps, then a final step that loads the result register, waiting on a pending result.
// The six-step microprogram over the single 32x32 multiplier takes a new item only when idle.
// Reset: synchronous; position and heading clear, turn_per_pulse loads 100000,
// no result pending.
module dead_reckoning_odometry #(
   parameter int SINE_TABLE_DEPTH = dro_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dro_req_if.sink                               req_if,
   dro_rsp_if.source                             rsp_if,
   input  logic                                  csr_wr_en,
   input  dro_pkg::csr_index_type                csr_index,
   input  logic [dro_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data
);
   import dro_pkg::*;

   localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int SHIFT_L  = (POSITION_FRACTION_BITS >= TABLE_FRACTION_BITS) ?
                             POSITION_FRACTION_BITS - TABLE_FRACTION_BITS : 0;
   localparam int SHIFT_R  = (POSITION_FRACTION_BITS < TABLE_FRACTION_BITS) ?
                             TABLE_FRACTION_BITS - POSITION_FRACTION_BITS : 0;
   localparam logic [31:0] TURN_RESET = 32'd100000;

   logic [STEP_BITS-1:0]              step_ff, step_in;
   ucode_type                         uc;
   logic                              fire;
   logic                              slot_free;

   logic [HEADING_WIDTH-1:0]          heading_ff, heading_in;
   logic [31:0]                       turn_ff, turn_in;
   logic [31:0]                       phase_ff;
   logic signed [DELTA_WIDTH-1:0]     dist_ff;
   logic signed [31:0]                prod_ff;
   logic signed [POS_WIDTH-1:0]       x_ff, x_in;
   logic signed [POS_WIDTH-1:0]       y_ff, y_in;
   logic                              flag_x_ff;

   logic signed [TRIG_WIDTH-1:0]      sin_val;
   logic signed [TRIG_WIDTH-1:0]      cos_val;
   logic [31:0]                       mul_a, mul_b, mul_lo;

   logic signed [POS_WIDTH-1:0]       delta;
   logic signed [POS_WIDTH-1:0]       acc_sel;
   logic signed [POS_WIDTH:0]         sum;
   logic signed [POS_WIDTH-1:0]       sat_val;
   logic                              sat_hit;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [POS_WIDTH-1:0]       rsp_x_ff, rsp_y_ff;
   logic [HEADING_WIDTH-1:0]          rsp_heading_ff;
   logic                              rsp_sat_ff;

   dro_sincos_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
      .clock   (clock),
      .rd_en   (uc.rom_rd),
      .addr    (phase_ff[31 -: IDX_BITS]),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   // sequencer
   assign uc        = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (uc.jump == JMP_WAIT_REQ);

   always_comb begin
      unique case (uc.jump)
         JMP_NEXT:     fire = 1'b1;
         JMP_WAIT_REQ: fire = req_if.valid;
         JMP_WAIT_RSP: fire = slot_free;
         default:      fire = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = (uc.jump == JMP_WAIT_RSP) ? '0 : step_ff + 1'b1;
      end
   end

   // shared multiplier, low 32 bits
   always_comb begin
      unique case (uc.mul_src)
         MUL_PHASE: begin mul_a = heading_ff; mul_b = turn_ff; end
         MUL_COS: begin
            mul_a = 32'(dist_ff);
            mul_b = 32'(cos_val);
         end
         MUL_SIN: begin
            mul_a = 32'(dist_ff);
            mul_b = 32'(sin_val);
         end
         default: begin mul_a = heading_ff; mul_b = turn_ff; end
      endcase
   end
   assign mul_lo = mul_a * mul_b;

   // Q.15 product to position format, then saturating add
   assign delta   = (POS_WIDTH'(prod_ff) <<< SHIFT_L) >>> SHIFT_R;
   assign acc_sel = uc.acc_x ? x_ff : y_ff;
   assign sum     = {acc_sel[POS_WIDTH-1], acc_sel} + {delta[POS_WIDTH-1], delta};
   assign sat_hit = sum[POS_WIDTH] != sum[POS_WIDTH-1];

   always_comb begin
      if (!sat_hit) begin
         sat_val = sum[POS_WIDTH-1:0];
      end else if (sum[POS_WIDTH]) begin
         sat_val = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   end

   // architectural state
   always_comb begin
      heading_in = heading_ff;
      turn_in    = turn_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TURN_PER_PULSE: turn_in    = csr_wr_data[31:0];
            CSR_START_X:        x_in       = csr_wr_data;
            CSR_START_Y:        y_in       = csr_wr_data;
            CSR_START_HEADING:  heading_in = csr_wr_data[HEADING_WIDTH-1:0];
            default:            turn_in    = turn_ff;
         endcase
      end else if (fire) begin
         if (uc.ld_heading) begin
            heading_in = heading_ff + HEADING_WIDTH'(req_if.delta_orientation);
         end
         if (uc.acc_x) begin
            x_in = sat_val;
         end
         if (uc.acc_y) begin
            y_in = sat_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         heading_ff <= '0;
         turn_ff    <= TURN_RESET;
         x_ff       <= '0;
         y_ff       <= '0;
      end else begin
         step_ff    <= step_in;
         heading_ff <= heading_in;
         turn_ff    <= turn_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && uc.ld_heading) begin
         dist_ff <= req_if.delta_distance;
      end
      if (uc.ld_phase) begin
         phase_ff <= mul_lo;
      end
      if (uc.ld_prod) begin
         prod_ff <= mul_lo;
      end
      if (uc.acc_x) begin
         flag_x_ff <= sat_hit;
      end
   end

   // result register
   assign rsp_valid_in = (fire && uc.acc_y) ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && uc.acc_y) begin
         rsp_x_ff       <= x_ff;
         rsp_y_ff       <= sat_val;
         rsp_heading_ff <= heading_ff;
         rsp_sat_ff     <= flag_x_ff | sat_hit;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pos_x     = rsp_x_ff;
   assign rsp_if.pos_y     = rsp_y_ff;
   assign rsp_if.heading   = rsp_heading_ff;
   assign rsp_if.saturated = rsp_sat_ff;

endmodule

@@ design/dro_sincos_rom.sv @@
// Quarter-wave sine/cosine ROM with registered read and quadrant folding.
module dro_sincos_rom #(
   parameter int SINE_TABLE_DEPTH = dro_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     rd_en,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]      addr,
   output logic signed [dro_pkg::TRIG_WIDTH-1:0]    sin_val,
   output logic signed [dro_pkg::TRIG_WIDTH-1:0]    cos_val
);
   import dro_pkg::*;

   localparam int IDX_BITS      = $clog2(SINE_TABLE_DEPTH);
   localparam int QUARTER_BITS  = IDX_BITS - 2;
   localparam int QUARTER_DEPTH = SINE_TABLE_DEPTH / 4;

   typedef logic [2*TRIG_WIDTH-1:0] rom_type [QUARTER_DEPTH];

   function automatic rom_type build_rom();
      rom_type     r;
      logic [63:0] x;
      for (int j = 0; j < QUARTER_DEPTH; j++) begin
         x    = (64'(j) * 64'd4 * HALF_PI_Q30) >> IDX_BITS;
         r[j] = quarter_entry(x);
      end
      return r;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [2*TRIG_WIDTH-1:0] entry_ff;
   quadrant_type            quad_ff;
   logic signed [TRIG_WIDTH-1:0] s_val;
   logic signed [TRIG_WIDTH-1:0] c_val;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_ff <= ROM[addr[QUARTER_BITS-1:0]];
         quad_ff  <= quadrant_type'(addr[IDX_BITS-1 -: 2]);
      end
   end

   assign s_val = entry_ff[2*TRIG_WIDTH-1:TRIG_WIDTH];
   assign c_val = entry_ff[TRIG_WIDTH-1:0];

   always_comb begin
      unique case (quad_ff)
         QUAD_0: begin sin_val = s_val;  cos_val = c_val;  end
         QUAD_1: begin sin_val = c_val;  cos_val = -s_val; end
         QUAD_2: begin sin_val = -s_val; cos_val = -c_val; end
         QUAD_3: begin sin_val = -c_val; cos_val = s_val;  end
         default: begin sin_val = s_val; cos_val = c_val;  end
      endcase
   end

endmodule

@@ test/dro_checker.sv @@
`timescale 1ns / 100ps
// Checker for the odometry block: tracks pose and registers, predicts each result and compares.
module dro_checker (
   input  logic                               clock,
   input  logic                               reset,
   dro_req_if                                 req,
   dro_rsp_if                                 rsp,
   input  logic                               csr_wr_en,
   input  dro_pkg::csr_index_type             csr_index,
   input  logic [dro_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 clipped_count
);
   import dro_pkg::*;

   localparam int          LUT_DEPTH    = SINE_TABLE_DEPTH_DEF;
   localparam logic [63:0] QUARTER_Q30  = 64'd1686629713;
   localparam logic [63:0] UNITY_Q30    = 64'd1 << 30;
   localparam logic [31:0] TURN_RESET   = 32'd100000;
   localparam int          SCALE_UP     = (POSITION_FRACTION_BITS > TABLE_FRACTION_BITS) ?
                                          POSITION_FRACTION_BITS - TABLE_FRACTION_BITS : 0;
   localparam int          SCALE_DOWN   = (TABLE_FRACTION_BITS > POSITION_FRACTION_BITS) ?
                                          TABLE_FRACTION_BITS - POSITION_FRACTION_BITS : 0;
   localparam longint      POS_TOP      = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
   localparam longint      POS_BOTTOM   = -(longint'(1) <<< (POS_WIDTH - 1));
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0]     pos_x;
      logic signed [POS_WIDTH-1:0]     pos_y;
      logic signed [HEADING_WIDTH-1:0] heading;
      logic                            saturated;
   } pose_type;

   logic signed [TRIG_WIDTH-1:0] sin_lut [LUT_DEPTH];
   logic signed [TRIG_WIDTH-1:0] cos_lut [LUT_DEPTH];

   logic [31:0]                 turn_per_pulse;
   logic signed [POS_WIDTH-1:0] x_pos;
   logic signed [POS_WIDTH-1:0] y_pos;
   logic [HEADING_WIDTH-1:0]    heading_pulses;

   pose_type expected_poses [$];
   int       reported;

   function automatic logic [TRIG_WIDTH-1:0] q30_to_q15(input longint v);
      logic [63:0] c;
      if (v < 0) begin
         c = 64'd0;
      end else if (v > longint'(UNITY_Q30)) begin
         c = UNITY_Q30;
      end else begin
         c = 64'(v);
      end
      return TRIG_WIDTH'((c * 64'd32767 + (64'd1 << 29)) >> 30);
   endfunction

   // Taylor series in Q2.30, terms alternate in sign
   function automatic void quadrant_trig(input logic [63:0] ang,
                                         output logic [TRIG_WIDTH-1:0] s,
                                         output logic [TRIG_WIDTH-1:0] c);
      logic [63:0] sq;
      logic [63:0] term;
      longint      acc;
      int          n;
      sq   = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (n = 1; n < 13; n += 2) begin
         term = term * sq / 64'((n + 1) * (n + 2));
         acc  = ((n / 2) % 2 == 0) ? acc - longint'(term) : acc + longint'(term);
      end
      s    = q30_to_q15(acc);
      term = UNITY_Q30;
      acc  = longint'(UNITY_Q30);
      for (n = 0; n < 14; n += 2) begin
         term = term * sq / 64'((n + 1) * (n + 2));
         acc  = ((n / 2) % 2 == 0) ? acc - longint'(term) : acc + longint'(term);
      end
      c = q30_to_q15(acc);
   endfunction

   initial begin : fill_luts
      logic [63:0]          m;
      logic [TRIG_WIDTH-1:0] s;
      logic [TRIG_WIDTH-1:0] c;
      quadrant_type          quad;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         m    = 64'(4 * k);
         quad = quadrant_type'(m / LUT_DEPTH);
         quadrant_trig((m % LUT_DEPTH) * QUARTER_Q30 / LUT_DEPTH, s, c);
         case (quad)
            QUAD_0: begin
               sin_lut[k] = s;
               cos_lut[k] = c;
            end
            QUAD_1: begin
               sin_lut[k] = c;
               cos_lut[k] = -s;
            end
            QUAD_2: begin
               sin_lut[k] = -s;
               cos_lut[k] = -c;
            end
            default: begin
               sin_lut[k] = -c;
               cos_lut[k] = s;
            end
         endcase
      end
   end

   function automatic longint to_position(input longint p);
      return (p <<< SCALE_UP) >>> SCALE_DOWN;
   endfunction

   function automatic logic signed [POS_WIDTH-1:0] clamp_add(
         input logic signed [POS_WIDTH-1:0] acc, input longint d, inout logic clipped);
      longint s;
      s = longint'(acc) + d;
      if (s > POS_TOP) begin
         clipped = 1'b1;
         s       = POS_TOP;
      end else if (s < POS_BOTTOM) begin
         clipped = 1'b1;
         s       = POS_BOTTOM;
      end
      return POS_WIDTH'(s);
   endfunction

   function automatic pose_type advance_pose(input logic signed [DELTA_WIDTH-1:0] distance,
                                             input logic signed [DELTA_WIDTH-1:0] turn);
      pose_type    p;
      logic [31:0] turn_frac;
      int          idx;
      logic        clipped;
      clipped        = 1'b0;
      heading_pulses = heading_pulses + {{(HEADING_WIDTH-DELTA_WIDTH){turn[DELTA_WIDTH-1]}}, turn};
      turn_frac      = heading_pulses * turn_per_pulse;
      idx            = int'((64'(turn_frac) * 64'(LUT_DEPTH)) >> 32);
      x_pos = clamp_add(x_pos, to_position(longint'(distance) * longint'(cos_lut[idx])),
                        clipped);
      y_pos = clamp_add(y_pos, to_position(longint'(distance) * longint'(sin_lut[idx])),
                        clipped);
      p.pos_x     = x_pos;
      p.pos_y     = y_pos;
      p.heading   = heading_pulses;
      p.saturated = clipped;
      return p;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      clipped_count = 0;
      reported      = 0;
   end

   always @(posedge clock) begin : monitor
      pose_type seen;
      pose_type want;
      if (reset) begin
         turn_per_pulse = TURN_RESET;
         x_pos          = '0;
         y_pos          = '0;
         heading_pulses = '0;
         expected_poses.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TURN_PER_PULSE: turn_per_pulse = csr_wr_data[31:0];
               CSR_START_X:        x_pos = csr_wr_data[POS_WIDTH-1:0];
               CSR_START_Y:        y_pos = csr_wr_data[POS_WIDTH-1:0];
               CSR_START_HEADING:  heading_pulses = csr_wr_data[HEADING_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            seen.pos_x     = rsp.pos_x;
            seen.pos_y     = rsp.pos_y;
            seen.heading   = rsp.heading;
            seen.saturated = rsp.saturated;
            if (seen.saturated === 1'b1) clipped_count++;
            if (expected_poses.size() == 0) begin
               fail_count++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("%t unexpected result x=%0d y=%0d heading=%0d sat=%b", $realtime,
                           seen.pos_x, seen.pos_y, seen.heading, seen.saturated);
               end
            end else begin
               want = expected_poses.pop_front();
               if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
                   seen.heading !== want.heading || seen.saturated !== want.saturated) begin
                  fail_count++;
                  if (reported < REPORT_LIMIT) begin
                     reported++;
                     $display("%t mismatch: expected x=%0d y=%0d heading=%0d sat=%b", $realtime,
                              want.pos_x, want.pos_y, want.heading, want.saturated);
                     $display("%t            got     x=%0d y=%0d heading=%0d sat=%b", $realtime,
                              seen.pos_x, seen.pos_y, seen.heading, seen.saturated);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            expected_poses.push_back(advance_pose(req.delta_distance, req.delta_orientation));
      end
      pending_count = expected_poses.size();
   end

endmodule

@@ test/tb_dead_reckoning_odometry.sv @@
`timescale 1ns / 100ps
// Testbench top for the odometry block: clock, reset, register settings, item traffic and verdict.
module tb_dead_reckoning_odometry;
   import dro_pkg::*;

   localparam int ITEM_TARGET = 1300;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 150;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_PHASE  = 3;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_SPARSE
   } rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   csr_index_type             csr_index = CSR_TURN_PER_PULSE;
   logic [CSR_DATA_WIDTH-1:0] csr_wr_data = '0;
   logic                      hold_req = 1'b0;

   int fail_count;
   int pending_count;
   int clipped_count;
   int items_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   dro_req_if req_ch ();
   dro_rsp_if rsp_ch ();

   dead_reckoning_odometry u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dro_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .clipped_count (clipped_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles with no item moving", quiet_cycles);
         $display("tb_dead_reckoning_odometry failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: changing stall pattern, plus one long hold-off on request
   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          tick;
      logic        hold_done;
      rsp_ch.ready = 1'b0;
      mode         = RX_OPEN;
      mode_left    = 0;
      tick         = 0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
               default:   rsp_ch.ready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_item(input logic [DELTA_WIDTH-1:0] distance,
                            input logic [DELTA_WIDTH-1:0] turn);
      @(negedge clock);
      req_ch.valid             <= 1'b1;
      req_ch.delta_distance    <= distance;
      req_ch.delta_orientation <= turn;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      pause_sender(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [DELTA_WIDTH-1:0] random_delta(input int span);
      logic [DELTA_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0, 1, 2: v = DELTA_WIDTH'($urandom_range(0, 16'hFFFF));
         3:       v = DELTA_WIDTH'($urandom_range(0, 2 * span)) - DELTA_WIDTH'(span);
         4:       v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: v = DELTA_WIDTH'($urandom_range(0, 2)) - 16'd1;
      endcase
      return v;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] random_setting(input csr_index_type idx);
      logic [CSR_DATA_WIDTH-1:0] v;
      logic [31:0]               r;
      r = $urandom;
      case (idx)
         CSR_TURN_PER_PULSE: begin
            case ($urandom_range(0, 5))
               0:       v = 48'd1;
               1:       v = 48'hFFFF_FFFF;
               2:       v = 48'd0;
               3:       v = 48'($urandom_range(1, 1 << 22));
               default: v = 48'(r);
            endcase
         end
         CSR_START_X, CSR_START_Y: begin
            case ($urandom_range(0, 5))
               0:       v = 48'h7FFF_FFFF_FFFF;
               1:       v = 48'h8000_0000_0000;
               2:       v = 48'd0;
               3:       v = {r, 16'($urandom)};
               default: v = {{16{r[31]}}, r};
            endcase
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 48'h7FFF_FFFF;
               1:       v = 48'h8000_0000;
               default: v = 48'(r);
            endcase
         end
      endcase
      return v;
   endfunction

   initial begin : stimulus
      csr_index_type idx;
      int            burst_left;
      int            phase_items;
      int            ph;
      req_ch.valid             = 1'b0;
      req_ch.delta_distance    = '0;
      req_ch.delta_orientation = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset values: field extremes
      settings_used++;
      send_item(16'h0000, 16'h0000);
      send_item(16'h7FFF, 16'h0000);
      send_item(16'h8000, 16'h0000);
      send_item(16'h0001, 16'h7FFF);
      send_item(16'h0001, 16'h8000);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h7FFF);
      send_item(16'hFFFF, 16'hFFFF);

      // zero turn factor, heading wraps both ways
      drain();
      write_reg(CSR_TURN_PER_PULSE, 48'd0);
      write_reg(CSR_START_HEADING, 48'h7FFF_FFFF);
      settings_used++;
      send_item(16'd100, 16'h0001);
      send_item(-16'sd100, 16'hFFFF);
      send_item(16'h7FFF, 16'h7FFF);

      // quarter turn per pulse near the position limits: clipping on x and y
      drain();
      write_reg(CSR_TURN_PER_PULSE, 48'h4000_0000);
      write_reg(CSR_START_X, 48'h7FFF_FFFF_FFFF - 48'd1000);
      write_reg(CSR_START_Y, 48'h8000_0000_0000 + 48'd1000);
      write_reg(CSR_START_HEADING, 48'd0);
      settings_used++;
      send_item(16'h7FFF, 16'h0000);
      send_item(16'h7FFF, 16'h0000);
      send_item(16'h7FFF, 16'h0002);
      send_item(16'h7FFF, 16'h0001);
      send_item(16'h8000, 16'h0000);
      send_item(16'h8000, 16'hFFFF);

      drain();
      write_reg(CSR_TURN_PER_PULSE, 48'hFFFF_FFFF);
      write_reg(CSR_START_X, 48'h8000_0000_0000);
      write_reg(CSR_START_Y, 48'h7FFF_FFFF_FFFF);
      write_reg(CSR_START_HEADING, 48'h8000_0000);
      settings_used++;
      send_item(16'h8000, 16'h0000);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h7FFF);

      // random settings and traffic in bursts
      burst_left = $urandom_range(1, 40);
      for (ph = 0; items_sent < ITEM_TARGET; ph++) begin
         drain();
         idx = idx.first();
         repeat (4) begin
            if ($urandom_range(0, 1)) write_reg(idx, random_setting(idx));
            idx = idx.next();
         end
         settings_used++;
         if (ph == HOLD_PHASE) hold_req = 1'b1;
         phase_items = $urandom_range(60, 140);
         while (phase_items > 0 && items_sent < ITEM_TARGET) begin
            send_item(random_delta(300), random_delta(64));
            phase_items--;
            burst_left--;
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
               burst_left = $urandom_range(1, 40);
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Covered %0d items under %0d register settings, %0d results clipped at the limits.",
               items_sent, settings_used, clipped_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_dead_reckoning_odometry passed");
      end else begin
         $display("%0d failures, %0d results outstanding", fail_count, pending_count);
         $display("tb_dead_reckoning_odometry failed");
      end
      $finish;
   end

endmodule
